[hdl/bsb_pkg.sv]
// Shared types, constants and helpers for the beam search backtrack block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bsb_pkg;

    // Field widths fixed by the item and result formats
    localparam int TIME_W  = 6;
    localparam int BEAM_W  = 4;
    localparam int TOKEN_W = 32;
    localparam int LEN_W   = 16;
    localparam int CNT_W   = 7;   // time step counts, 1..64

    // Default sizes of the stores
    localparam int TIME_DEPTH_DEF = 64;
    localparam int MAX_BEAMS_DEF  = 16;

    // Depth of the command queue between front and back (power of two)
    localparam int Q_DEPTH = 2;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_RUN  = 1'b1
    } op_t;

    // Register index, taken from paddr[2]
    typedef enum logic
    {
        REG_EOS_TOK    = 1'b0,
        REG_TIME_STEPS = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0]
    {
        BK_IDLE,
        BK_WALK,
        BK_DRAIN,
        BK_EMIT
    } bk_state_t;

    typedef struct packed
    {
        logic                      action;
        logic [TIME_W-1:0]         time_pos;
        logic [BEAM_W-1:0]         beam_pos;
        logic signed [TOKEN_W-1:0] step_token;
        logic [BEAM_W-1:0]         parent_beam;
        logic [LEN_W-1:0]          seq_len;
    } item_t;

    typedef struct packed
    {
        logic [TIME_W-1:0]         time_pos_out;
        logic signed [TOKEN_W-1:0] token;
        logic                      last;
    } result_t;

    // Classified command word passed from front to back
    typedef struct packed
    {
        op_t                op;
        logic [TIME_W-1:0]  time_pos;
        logic [BEAM_W-1:0]  beam;
        logic [TOKEN_W-1:0] token;
        logic [BEAM_W-1:0]  parent;
        logic [CNT_W-1:0]   steps;
        logic [CNT_W-1:0]   len;
    } cmd_t;

    // Beam indexes at or beyond the beam count fold onto the last beam
    function automatic logic [BEAM_W-1:0] clamp_beam(input logic [BEAM_W-1:0] b,
                                                     input int unsigned max_beams);
        logic [BEAM_W-1:0] r;
        if (int'(b) >= int'(max_beams))
            r = BEAM_W'(max_beams - 1);
        else
            r = b;
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/bsb_front.sv]
// Front end: takes input words, drops out-of-range loads and prepares run
// commands (clamped step count, length and beam). Uses bsb_pkg.
`default_nettype none

module bsb_front
    import bsb_pkg::*;
#(
    parameter int TIME_DEPTH = TIME_DEPTH_DEF,
    parameter int MAX_BEAMS  = MAX_BEAMS_DEF
)
(
    input  wire logic             start,
    input  wire logic             busy,
    input  wire item_t            item,
    input  wire logic [CNT_W-1:0] time_steps,
    output logic                  push,
    output cmd_t                  cmd
);

    logic             accept;
    logic             is_run;
    logic             in_range;
    logic [CNT_W-1:0] steps;
    logic [CNT_W-1:0] len;

    assign accept = start && !busy;
    assign is_run = (op_t'(item.action) == OP_RUN);

    // Loads outside the store are dropped
    assign in_range = (int'(item.time_pos) < TIME_DEPTH) && (int'(item.beam_pos) < MAX_BEAMS);

    // Step count in use: zero reads as one, capped at the store depth
    always_comb
    begin
        if (time_steps == '0)
            steps = CNT_W'(1);
        else if (int'(time_steps) > TIME_DEPTH)
            steps = CNT_W'(TIME_DEPTH);
        else
            steps = time_steps;
    end

    assign len = (item.seq_len < LEN_W'(steps)) ? CNT_W'(item.seq_len) : steps;

    assign push = accept && (is_run || in_range);

    // Command word
    always_comb
    begin
        cmd.op       = is_run ? OP_RUN : OP_LOAD;
        cmd.time_pos = item.time_pos;
        cmd.beam     = is_run ? clamp_beam(item.beam_pos, MAX_BEAMS) : item.beam_pos;
        cmd.token    = item.step_token;
        cmd.parent   = item.parent_beam;
        cmd.steps    = steps;
        cmd.len      = len;
    end

endmodule

`default_nettype wire

[hdl/bsb_queue.sv]
// Short command queue between front and back ends.
// Uses bsb_pkg for the command word type and depth.
`default_nettype none

module bsb_queue
    import bsb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output logic      full,
    output logic      valid,
    output cmd_t      head
);

    localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    cmd_t          q_mem [Q_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full  = (count_reg == CW'(Q_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = q_mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= push_cmd;
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("queue read while empty");

    a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + CW'(1))
        else $error("queue count did not advance on write");
`endif

endmodule

`default_nettype wire

[hdl/bsb_back.sv]
// Back end: executes queued commands. Holds the token/parent store and the
// path buffer, walks parents backward, then emits tokens forward with end
// fill. Uses bsb_pkg.
`default_nettype none

module bsb_back
    import bsb_pkg::*;
#(
    parameter int TIME_DEPTH = TIME_DEPTH_DEF,
    parameter int MAX_BEAMS  = MAX_BEAMS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire cmd_t               q_head,
    output logic                    q_pop,
    input  wire logic [TOKEN_W-1:0] eos_tok,
    output logic                    result_stb,
    output result_t                 result
);

    localparam int TW    = (TIME_DEPTH > 1) ? $clog2(TIME_DEPTH) : 1;
    localparam int BW    = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1;
    localparam int SAW   = TW + BW;
    localparam int SDEPTH = TIME_DEPTH << BW;
    localparam int SW    = TOKEN_W + BEAM_W;

    bk_state_t state_reg, state_next;

    // Run context
    logic [TW-1:0]      ti_reg, ti_next;
    logic [TW-1:0]      rt_reg, rt_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic [CNT_W-1:0]   steps_reg, steps_next;
    logic [BEAM_W-1:0]  beam_reg, beam_next;
    logic               pend_reg, pend_next;
    logic [TW-1:0]      pend_ti_reg, pend_ti_next;

    // Emit pipeline
    logic               emit_vld_reg, emit_vld_next;
    logic [TW-1:0]      emit_t_reg, emit_t_next;
    logic               emit_last_reg, emit_last_next;
    logic               ended_reg, ended_next;
    logic               res_stb_reg, res_stb_next;
    result_t            res_reg, res_next;

    // Memories
    logic [SW-1:0]      store_mem [SDEPTH];
    logic [SW-1:0]      store_rd_reg;
    logic [TOKEN_W-1:0] path_mem [TIME_DEPTH];
    logic [TOKEN_W-1:0] path_rd_reg;

    logic               store_we, store_re;
    logic [SAW-1:0]     store_waddr, store_raddr;
    logic [SW-1:0]      store_wdata;
    logic               path_we, path_re;
    logic [TW-1:0]      path_waddr;
    logic [TOKEN_W-1:0] path_wdata;

    logic [TOKEN_W-1:0] rd_token;
    logic [BEAM_W-1:0]  rd_parent;
    logic [BEAM_W-1:0]  beam_cur;
    logic               ti_in_len;
    logic               walk_done;
    logic               emit_done;
    logic [TOKEN_W-1:0] tok_val;

    assign rd_token  = store_rd_reg[SW-1 -: TOKEN_W];
    assign rd_parent = store_rd_reg[BEAM_W-1:0];

    // Beam at the current walk step: the run beam first, then stored parents
    assign beam_cur  = pend_reg ? clamp_beam(rd_parent, MAX_BEAMS) : beam_reg;
    assign ti_in_len = (CNT_W'(ti_reg) < len_reg);
    assign walk_done = (ti_reg == '0);
    assign emit_done = ((CNT_W'(rt_reg) + CNT_W'(1)) == steps_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && q_head.op == OP_RUN)
                    state_next = BK_WALK;
            end
            BK_WALK:
            begin
                if (walk_done)
                    state_next = BK_DRAIN;
            end
            BK_DRAIN:
                state_next = BK_EMIT;
            BK_EMIT:
            begin
                if (emit_done)
                    state_next = BK_IDLE;
            end
            default:
                state_next = BK_IDLE;
        endcase
    end

    // Control outputs and memory ports
    always_comb
    begin
        q_pop       = 1'b0;
        store_we    = 1'b0;
        store_waddr = {TW'(q_head.time_pos), BW'(q_head.beam)};
        store_wdata = {q_head.token, q_head.parent};
        store_re    = 1'b0;
        store_raddr = {ti_reg, BW'(beam_cur)};
        path_re     = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                q_pop    = q_valid;
                store_we = q_valid && (q_head.op == OP_LOAD);
            end
            BK_WALK:
                store_re = ti_in_len;
            BK_DRAIN:
                ;
            BK_EMIT:
                path_re = 1'b1;
            default:
                ;
        endcase

        // A pending store read lands in the buffer; padded steps get the end token
        path_we    = 1'b0;
        path_waddr = ti_reg;
        path_wdata = eos_tok;
        if (pend_reg)
        begin
            path_we    = 1'b1;
            path_waddr = pend_ti_reg;
            path_wdata = rd_token;
        end
        else if (state_reg == BK_WALK && !ti_in_len)
        begin
            path_we = 1'b1;
        end
    end

    // Run context update
    always_comb
    begin
        ti_next      = ti_reg;
        rt_next      = rt_reg;
        len_next     = len_reg;
        steps_next   = steps_reg;
        beam_next    = beam_reg;
        pend_next    = (state_reg == BK_WALK) && ti_in_len;
        pend_ti_next = ti_reg;
        case (state_reg)
            BK_IDLE:
            begin
                len_next   = q_head.len;
                steps_next = q_head.steps;
                beam_next  = q_head.beam;
                ti_next    = TW'(q_head.steps - CNT_W'(1));
            end
            BK_WALK:
            begin
                beam_next = beam_cur;
                if (!walk_done)
                    ti_next = ti_reg - TW'(1);
            end
            BK_DRAIN:
                rt_next = '0;
            BK_EMIT:
                rt_next = rt_reg + TW'(1);
            default:
                ;
        endcase
    end

    // Emit pipeline: buffer read, then end fill into the result register
    always_comb
    begin
        emit_vld_next  = (state_reg == BK_EMIT);
        emit_t_next    = rt_reg;
        emit_last_next = emit_done;

        tok_val = (emit_t_reg != '0 && ended_reg) ? eos_tok : path_rd_reg;

        ended_next   = emit_vld_reg ? (tok_val == eos_tok) : ended_reg;
        res_stb_next = emit_vld_reg;
        res_next.time_pos_out = TIME_W'(emit_t_reg);
        res_next.token        = tok_val;
        res_next.last         = emit_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            pend_reg     <= 1'b0;
            emit_vld_reg <= 1'b0;
            ended_reg    <= 1'b0;
            res_stb_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            emit_vld_reg <= emit_vld_next;
            ended_reg    <= ended_next;
            res_stb_reg  <= res_stb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ti_reg        <= ti_next;
        rt_reg        <= rt_next;
        len_reg       <= len_next;
        steps_reg     <= steps_next;
        beam_reg      <= beam_next;
        pend_ti_reg   <= pend_ti_next;
        emit_t_reg    <= emit_t_next;
        emit_last_reg <= emit_last_next;
        res_reg       <= res_next;
    end

    // Token and parent store
    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[store_waddr] <= store_wdata;
        if (store_re)
            store_rd_reg <= store_mem[store_raddr];
    end

    // Path buffer
    always_ff @(posedge clk)
    begin
        if (path_we)
            path_mem[path_waddr] <= path_wdata;
        if (path_re)
            path_rd_reg <= path_mem[rt_reg];
    end

    assign result_stb = res_stb_reg;
    assign result     = res_reg;

`ifndef ASSERT_OFF
    a_emit_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        result_stb && !result.last |=>
            result_stb && (result.time_pos_out == $past(result.time_pos_out) + TIME_W'(1)))
        else $error("result words of one run not back to back");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_stb && result.last |=> !result_stb)
        else $error("result word right after the final one");

    a_run_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_stb) |-> result.time_pos_out == '0)
        else $error("run did not start at time zero");

    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        store_we |-> state_reg == BK_IDLE && !store_re)
        else $error("store written during a run");
`endif

endmodule

`default_nettype wire

[hdl/beam_search_backtrack_top.sv]
// Top level of the beam search backtrack block: configuration registers,
// front end, command queue and back end. Uses bsb_pkg, bsb_front,
// bsb_queue and bsb_back.
`default_nettype none

// A word is taken when start is high and busy is low. A load word is written
// into the token/parent store as the idle back end dequeues it, so loads
// stream at one per cycle while no run holds the back end. A run word with S
// steps in use (time_steps clamped to 1..TIME_DEPTH) holds the back end while
// it is dequeued, walks the parent chain through the store (one registered
// read per step), drains the last read and reads the path buffer out. Its S
// result words appear on consecutive cycles, time 0 first, via the path buffer
// read, emit and result registers; result_stb marks each and the receiver has
// no way to stall them. A two-entry queue lets new words be taken while a run
// is under way; busy rises when it is full. Store contents are undefined until
// loaded and there is no clearing pass after reset. Registers: end token at
// 0x0, time_steps at 0x4; write them only while the block is idle.

module beam_search_backtrack_top
    import bsb_pkg::*;
#(
    parameter int TIME_DEPTH = TIME_DEPTH_DEF,
    parameter int MAX_BEAMS  = MAX_BEAMS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Command side
    input  wire logic                  start,
    output logic                       busy,
    input  wire item_t                 item,
    // Result side
    output logic                       result_stb,
    output result_t                    result,
    // Configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic [TOKEN_W-1:0] eos_tok_reg, eos_tok_next;
    logic [CNT_W-1:0]   time_steps_reg, time_steps_next;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;

    logic               push;
    cmd_t               push_cmd;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    cmd_t               q_head;

    // Register file
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_comb
    begin
        eos_tok_next    = eos_tok_reg;
        time_steps_next = time_steps_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                REG_EOS_TOK:    eos_tok_next    = pwdata[TOKEN_W-1:0];
                REG_TIME_STEPS: time_steps_next = pwdata[CNT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eos_tok_reg    <= '0;
            time_steps_reg <= CNT_W'(64);
        end
        else
        begin
            eos_tok_reg    <= eos_tok_next;
            time_steps_reg <= time_steps_next;
        end
    end

    // Read back
    always_comb
    begin
        case (cfg_idx)
            REG_EOS_TOK:    prdata = eos_tok_reg;
            REG_TIME_STEPS: prdata = CFG_DATA_W'(time_steps_reg);
            default:        prdata = '0;
        endcase
    end

    assign busy = q_full;

    bsb_front #(
        .TIME_DEPTH (TIME_DEPTH),
        .MAX_BEAMS  (MAX_BEAMS)
    ) u_front (
        .start      (start),
        .busy       (q_full),
        .item       (item),
        .time_steps (time_steps_reg),
        .push       (push),
        .cmd        (push_cmd)
    );

    bsb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .valid    (q_valid),
        .head     (q_head)
    );

    bsb_back #(
        .TIME_DEPTH (TIME_DEPTH),
        .MAX_BEAMS  (MAX_BEAMS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .eos_tok    (eos_tok_reg),
        .result_stb (result_stb),
        .result     (result)
    );

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for beam_search_backtrack_top: command words in,
// token words out, registers over the APB-style port. Depends on bsb_pkg.

module tb;
    import bsb_pkg::*;

    localparam int MAX_T     = TIME_DEPTH_DEF;
    localparam int NBEAM     = MAX_BEAMS_DEF;
    localparam int DEPTH     = MAX_T * NBEAM;
    localparam int IDLE_GAP  = 16;       // loads still queued behind the last run
    localparam int LIMIT     = 300000;
    localparam int PHASES    = 7;
    localparam int PRINT_CAP = 50;

    typedef enum logic
    {
        ROW_WORD,
        ROW_REG
    } row_kind_t;

    // One line of the directed plan: a command word or a register write.
    // fixed marks a run whose tokens are all known in advance.
    typedef struct
    {
        row_kind_t                 kind;
        item_t                     w;
        reg_idx_t                  ridx;
        logic [CFG_DATA_W-1:0]     value;
        bit                        fixed;
        logic signed [TOKEN_W-1:0] ftok;
    } row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    item_t                 item_in;
    logic                  result_stb;
    result_t               res_out;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor state: register copies and the token/parent stores
    logic signed [TOKEN_W-1:0] cfg_end;
    logic [CNT_W-1:0]          cfg_steps;
    logic signed [TOKEN_W-1:0] token_mem [DEPTH];
    logic [BEAM_W-1:0]         parent_mem [DEPTH];
    bit                        loaded [DEPTH];

    result_t expected_tokens [$];
    row_t    plan [$];

    int err_count   = 0;
    int cycle_count = 0;
    int words_sent  = 0;
    int burst_left  = 0;

    logic [31:0]      phase_end [PHASES];
    logic [CNT_W-1:0] phase_steps [PHASES];
    int               phase_budget [PHASES];

    beam_search_backtrack_top DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item_in),
        .result_stb (result_stb),
        .result     (res_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic note_mismatch(input string what);
        if (err_count < PRINT_CAP)
            $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
        err_count++;
    endtask

    // Result checker: each strobed word against the oldest expectation
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && result_stb)
        begin
            if (expected_tokens.size() == 0)
                note_mismatch($sformatf("unexpected word t=%0d tok=%0d last=%0b",
                                        res_out.time_pos_out, res_out.token, res_out.last));
            else
            begin
                e = expected_tokens.pop_front();
                if (res_out.time_pos_out !== e.time_pos_out)
                    note_mismatch($sformatf("time_pos_out %0d, want %0d",
                                            res_out.time_pos_out, e.time_pos_out));
                if (res_out.token !== e.token)
                    note_mismatch($sformatf("token at t=%0d: %0d, want %0d",
                                            e.time_pos_out, res_out.token, e.token));
                if (res_out.last !== e.last)
                    note_mismatch($sformatf("last at t=%0d: %b, want %b",
                                            e.time_pos_out, res_out.last, e.last));
            end
        end
    end

    // time_steps as the block uses it: 0 acts as 1, above MAX_T acts as MAX_T
    function automatic int steps_used();
        int s;
        s = int'(cfg_steps);
        if (s == 0)
            s = 1;
        if (s > MAX_T)
            s = MAX_T;
        return s;
    endfunction

    function automatic item_t random_word();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(item_t)-1:0];
    endfunction

    // Favor the end token and the extremes so end fill happens often
    function automatic logic signed [TOKEN_W-1:0] pick_token();
        logic signed [TOKEN_W-1:0] v;
        case ($urandom_range(0, 7))
            0, 1:    v = cfg_end;
            2:       v = 32'sh8000_0000;
            3:       v = 32'sh7FFF_FFFF;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Predictor: update the stores on a load, or backtrack and queue the
    // expected tokens of a run. With 16 beams every 4-bit index is in range.
    task automatic take_word(input item_t w, input bit fixed,
                             input logic signed [TOKEN_W-1:0] ftok);
        logic signed [TOKEN_W-1:0] path [MAX_T];
        logic signed [TOKEN_W-1:0] v;
        logic [BEAM_W-1:0]         b;
        result_t                   r;
        int                        steps, len, t, idx;
        bit                        ended;
        if (w.action == OP_LOAD)
        begin
            idx = int'(w.time_pos) * NBEAM + int'(w.beam_pos);
            token_mem[idx]  = w.step_token;
            parent_mem[idx] = w.parent_beam;
            loaded[idx]     = 1'b1;
        end
        else
        begin
            steps = steps_used();
            len   = (int'(w.seq_len) < steps) ? int'(w.seq_len) : steps;
            b     = w.beam_pos;
            // walk back from the last step in use
            for (t = steps - 1; t >= 0; t--)
            begin
                if (fixed)
                    path[t] = ftok;
                else if (t >= len)
                    path[t] = cfg_end;
                else
                begin
                    idx     = t * NBEAM + int'(b);
                    path[t] = token_mem[idx];
                    b       = parent_mem[idx];
                end
            end
            // emit in time order; everything after the first end token is end
            ended = 1'b0;
            for (t = 0; t < steps; t++)
            begin
                v = ended ? cfg_end : path[t];
                if (v == cfg_end)
                    ended = 1'b1;
                r.time_pos_out = TIME_W'(t);
                r.token        = v;
                r.last         = (t == steps - 1);
                expected_tokens.insert(expected_tokens.size(), r);
            end
        end
    endtask

    // Drive one word; bursts of random length separated by random gaps
    task automatic send_word(input item_t w, input bit fixed,
                             input logic signed [TOKEN_W-1:0] ftok);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        start   <= 1'b1;
        item_in <= w;
        do
            @(posedge clk);
        while (busy);
        take_word(w, fixed, ftok);
        words_sent++;
        @(negedge clk);
    endtask

    // Quiet the command side and wait until all tokens are back
    task automatic settle();
        start <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (IDLE_GAP) @(posedge clk);
        @(negedge clk);
    endtask

    // One write, then the port is returned to idle
    task automatic write_reg(input reg_idx_t ridx, input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {ridx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (ridx == REG_EOS_TOK)
            cfg_end = value;
        else
            cfg_steps = value[CNT_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // A run whose parent chain is loaded first wherever it is still empty
    task automatic issue_run(input logic [BEAM_W-1:0] b0, input logic [LEN_W-1:0] slen);
        item_t             w;
        logic [BEAM_W-1:0] b;
        int                steps, len, t, idx;
        steps = steps_used();
        len   = (int'(slen) < steps) ? int'(slen) : steps;
        b     = b0;
        for (t = len - 1; t >= 0; t--)
        begin
            idx = t * NBEAM + int'(b);
            if (!loaded[idx])
            begin
                w            = random_word();
                w.action     = OP_LOAD;
                w.time_pos   = TIME_W'(t);
                w.beam_pos   = b;
                w.step_token = pick_token();
                send_word(w, 1'b0, '0);
            end
            b = parent_mem[idx];
        end
        w          = random_word();
        w.action   = OP_RUN;
        w.beam_pos = b0;
        w.seq_len  = slen;
        send_word(w, 1'b0, '0);
    endtask

    // Directed plan builders
    task automatic plan_load(input int t, input int b, input logic [31:0] tok, input int par);
        row_t r;
        r.kind          = ROW_WORD;
        r.w             = random_word();
        r.w.action      = OP_LOAD;
        r.w.time_pos    = TIME_W'(t);
        r.w.beam_pos    = BEAM_W'(b);
        r.w.step_token  = tok;
        r.w.parent_beam = BEAM_W'(par);
        r.fixed         = 1'b0;
        r.ftok          = '0;
        plan.insert(plan.size(), r);
    endtask

    task automatic plan_run(input int b, input int slen, input bit fixed,
                            input logic [31:0] ftok);
        row_t r;
        r.kind       = ROW_WORD;
        r.w          = random_word();
        r.w.action   = OP_RUN;
        r.w.beam_pos = BEAM_W'(b);
        r.w.seq_len  = LEN_W'(slen);
        r.fixed      = fixed;
        r.ftok       = ftok;
        plan.insert(plan.size(), r);
    endtask

    task automatic plan_reg(input reg_idx_t ridx, input logic [31:0] value);
        row_t r;
        r.kind  = ROW_REG;
        r.ridx  = ridx;
        r.value = value;
        r.fixed = 1'b0;
        plan.insert(plan.size(), r);
    endtask

    initial
    begin
        int     p, first, n;
        item_t  w;

        start     = 1'b0;
        item_in   = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        rst_n     = 1'b0;
        cfg_end   = '0;
        cfg_steps = CNT_W'(64);

        phase_end    = '{32'h8000_0000, 32'h7FFF_FFFF, $urandom, 32'h0,
                         32'hFFFF_FFFF, $urandom, 32'd2};
        phase_steps  = '{7'd1, 7'd3, 7'($urandom_range(2, 9)), 7'd5, 7'd64, 7'd65, 7'd7};
        phase_budget = '{25, 25, 25, 25, 10, 10, 25};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // After reset: 64 steps, end token 0; zero length gives all end tokens
        plan_run(3, 0, 1'b1, 32'h0);
        plan_reg(REG_TIME_STEPS, 32'd4);
        plan_reg(REG_EOS_TOK, 32'd7);
        // Two interleaved chains over beams 0 and 15, extreme tokens
        plan_load(0, 15, 32'h8000_0000, 0);
        plan_load(0, 0,  32'hFFFF_FFFF, 15);
        plan_load(1, 0,  32'h7FFF_FFFF, 15);
        plan_load(1, 15, 32'h0, 0);
        plan_load(2, 15, 32'd7, 0);                // end token mid-path
        plan_load(2, 0,  32'd123, 15);
        plan_load(3, 0,  32'hFFFF_FFFB, 0);
        plan_load(3, 15, 32'd9, 15);
        plan_load(63, 15, 32'h1234_5678, 15);      // top time step
        plan_run(15, 65535, 1'b0, 32'h0);          // length clamped, end fill
        plan_run(0, 4, 1'b0, 32'h0);
        plan_run(0, 2, 1'b0, 32'h0);
        plan_run(15, 0, 1'b1, 32'd7);
        plan_run(0, 1, 1'b0, 32'h0);
        // End token zero: the zero token at time 1 ends the sequence
        plan_reg(REG_EOS_TOK, 32'h0);
        plan_run(0, 4, 1'b0, 32'h0);
        // time_steps 0 acts as one step
        plan_reg(REG_TIME_STEPS, 32'd0);
        plan_run(15, 65535, 1'b0, 32'h0);
        // time_steps above the maximum acts as 64
        plan_reg(REG_TIME_STEPS, 32'd127);
        plan_run(7, 0, 1'b1, 32'h0);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                settle();
                write_reg(plan[i].ridx, plan[i].value);
            end
            else
                send_word(plan[i].w, plan[i].fixed, plan[i].ftok);
        end

        // Random phases: a few stray loads, then, most of the time, a run over a loaded chain
        for (p = 0; p < PHASES; p++)
        begin
            settle();
            write_reg(REG_EOS_TOK, phase_end[p]);
            write_reg(REG_TIME_STEPS, 32'(phase_steps[p]));
            first = words_sent;
            while (words_sent - first < phase_budget[p])
            begin
                n = $urandom_range(0, 3);
                repeat (n)
                begin
                    w            = random_word();
                    w.action     = OP_LOAD;
                    w.step_token = pick_token();
                    if ($urandom_range(0, 1) == 0)
                        w.time_pos = TIME_W'($urandom_range(0, steps_used() - 1));
                    send_word(w, 1'b0, '0);
                end
                if ($urandom_range(0, 9) != 0)
                begin
                    case ($urandom_range(0, 5))
                        0:       issue_run(BEAM_W'($urandom), '0);
                        1:       issue_run(BEAM_W'($urandom), '1);
                        2:       issue_run(BEAM_W'($urandom), LEN_W'($urandom));
                        default: issue_run(BEAM_W'($urandom),
                                           LEN_W'($urandom_range(0, steps_used() + 1)));
                    endcase
                end
            end
        end

        settle();
        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

[files.f]
hdl/bsb_pkg.sv
hdl/bsb_front.sv
hdl/bsb_queue.sv
hdl/bsb_back.sv
hdl/beam_search_backtrack_top.sv
tb/tb.sv
